// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the log2 pipeline modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define FPL2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge.
`define FPL2_NEVER(lbl, expr, msg) \
	`FPL2_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/fpl2_pkg.sv -----
// Constants, stage payload type and helper functions of the log2 pipeline.
package fpl2_pkg;

	localparam int IN_WIDTH  = 64;
	localparam int FRAC_BITS = 5;
	localparam int VAL_W     = 64;
	localparam int POS_W     = 6;
	localparam int LOG_W     = POS_W + FRAC_BITS;
	localparam int TBL_LEN   = 5;
	localparam int COEF_W    = 16;
	localparam int STEP_FRAC = 15;
	// running product keeps enough fraction bits for every cell but the last
	localparam int T_FRAC    = STEP_FRAC * (TBL_LEN - 1);
	localparam int T_W       = T_FRAC + 1;
	localparam int PROD_W    = T_W + COEF_W;
	localparam int CMP_FRAC  = T_FRAC + STEP_FRAC;
	localparam int MANT_PAD  = CMP_FRAC - (VAL_W - 1);

	localparam logic [VAL_W-1:0] IN_MASK = {VAL_W{1'b1}} >> (VAL_W - IN_WIDTH);
	localparam logic [T_W-1:0]   T_ONE   = {1'b1, {T_FRAC{1'b0}}};

	// 2^(1/2^(k+1)) in Q1.15
	localparam logic [COEF_W-1:0] ROOT_TBL [TBL_LEN] = '{
		16'hB504, 16'h9837, 16'h8B95, 16'h85AA, 16'h82CD
	};

	typedef struct packed {
		logic                 zero;
		logic [POS_W-1:0]     pos;
		logic [VAL_W-1:0]     mant;
		logic [T_W-1:0]       t;
		logic [FRAC_BITS-1:0] frac;
	} fpl2_stage_t;

	// Leading-one position: per-byte encoders, then pick the highest busy byte.
	function automatic logic [POS_W-1:0] lead_one(input logic [VAL_W-1:0] v);
		logic [7:0] any_b;
		logic [2:0] sub [8];
		logic [2:0] hi;
		for (int b = 0; b < 8; b++) begin
			any_b[b] = |v[8*b +: 8];
			sub[b]   = 3'd0;
			for (int i = 0; i < 8; i++) begin
				if (v[8*b + i]) begin
					sub[b] = 3'(i);
				end
			end
		end
		hi = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (any_b[b]) begin
				hi = 3'(b);
			end
		end
		return {hi, sub[hi]};
	endfunction

	function automatic logic [LOG_W-1:0] pack_log(input fpl2_stage_t s);
		if (s.zero) begin
			return {LOG_W{1'b1}};
		end
		return {s.pos, s.frac};
	endfunction

endpackage

// ----- hw/rtl/fpl2_in_if.sv -----
// Input channel: one 64-bit unsigned value per transaction.
interface fpl2_in_if import fpl2_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/fpl2_out_if.sv -----
// Output channel: Q6.5 logarithm and zero-input flag per transaction.
interface fpl2_out_if import fpl2_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LOG_W-1:0] log_value;
	logic             input_zero;

	modport source (output valid, output log_value, output input_zero, input ready);
	modport sink   (input valid, input log_value, input input_zero, output ready);
endinterface

// ----- hw/rtl/fpl2_lead.sv -----
// Front end: leading-one search, then normalization of the input to 1.x form.
`include "assert_macros.svh"

module fpl2_lead import fpl2_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [VAL_W-1:0] value,
	output logic             dn_valid,
	input  logic             dn_ready,
	output fpl2_stage_t      dn
);

	logic             v_s1;
	logic             zero_s1;
	logic [POS_W-1:0] pos_s1;
	logic [VAL_W-1:0] val_s1;
	logic             v_s2;
	fpl2_stage_t      stage_s2;
	logic             en1;
	logic             en2;
	logic [VAL_W-1:0] masked;

	assign masked   = value & IN_MASK;
	assign en2      = !v_s2 || dn_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			val_s1  <= masked;
			pos_s1  <= lead_one(masked);
			zero_s1 <= (masked == '0);
		end
		if (en2 && v_s1) begin
			stage_s2.zero <= zero_s1;
			stage_s2.pos  <= pos_s1;
			// shift by 63 - pos puts the leading one at the top
			stage_s2.mant <= val_s1 << ~pos_s1;
			stage_s2.t    <= T_ONE;
			stage_s2.frac <= '0;
		end
	end

	assign dn_valid = v_s2;
	assign dn       = stage_s2;

	`FPL2_ASSERT(a_mant_norm, v_s2 && !stage_s2.zero |-> stage_s2.mant[VAL_W-1], "mantissa not normalized")

endmodule

// ----- hw/rtl/fpl2_cell.sv -----
// One fraction cell: multiply by a root constant, compare with the mantissa, settle one bit.
`include "assert_macros.svh"

module fpl2_cell import fpl2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [COEF_W-1:0] coef,
	input  logic              up_valid,
	output logic              up_ready,
	input  fpl2_stage_t       up,
	output logic              dn_valid,
	input  logic              dn_ready,
	output fpl2_stage_t       dn
);

	logic              v_q;
	fpl2_stage_t       st_q;
	logic              en;
	logic [PROD_W-1:0] cand;
	logic [PROD_W-1:0] target;
	logic              take;

	assign en       = !v_q || dn_ready;
	assign up_ready = en;

	// both sides carry CMP_FRAC fraction bits
	assign cand   = PROD_W'(up.t) * PROD_W'(coef);
	assign target = PROD_W'({up.mant, {MANT_PAD{1'b0}}});
	assign take   = (cand <= target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			st_q.zero <= up.zero;
			st_q.pos  <= up.pos;
			st_q.mant <= up.mant;
			// keep the product when the bit is set; it stays below 2.0
			st_q.t    <= take ? cand[STEP_FRAC +: T_W] : up.t;
			st_q.frac <= FRAC_BITS'({up.frac, take});
		end
	end

	assign dn_valid = v_q;
	assign dn       = st_q;

	`FPL2_ASSERT(a_prod_range, v_q |-> st_q.t[T_W-1], "running product left [1,2)")

endmodule

// ----- hw/rtl/fixed_point_log2_core.sv -----
// Top level of the pipelined fixed-point log2 unit.
//
// Usage:
//   data_in carries one unsigned 64-bit value per transaction; data_out returns
//   log2 of it in Q6.5 (integer part = leading-one position, five fraction
//   bits) together with input_zero. A zero input gives input_zero = 1 and
//   log_value all ones.
//   From acceptance to the result showing valid, a transaction passes two front
//   stages (leading-one search, normalizing shift) and one cell per fraction
//   bit. Each cell holds one 61x16 multiply and a 77-bit compare.
//   Throughput is one transaction per cycle; results leave in input order.
//   Each stage has its own valid bit and takes a new transaction whenever it
//   is empty or its successor advances, so bubbles close up.
//   When the receiver stalls, results back up stage by stage; data_in.ready
//   drops only once every stage holds a transaction.
//   Reset clears all valid bits; no clearing pass is needed, and the block
//   accepts a transaction in the first cycle after reset is released.
`include "assert_macros.svh"

module fixed_point_log2_core import fpl2_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fpl2_in_if.sink      data_in,
	fpl2_out_if.source   data_out
);

	logic        vld [FRAC_BITS+1];
	logic        rdy [FRAC_BITS+1];
	fpl2_stage_t stg [FRAC_BITS+1];

	fpl2_lead u_lead (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (data_in.valid),
		.in_ready (data_in.ready),
		.value    (data_in.value),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0]),
		.dn       (stg[0])
	);

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
		fpl2_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.coef     (ROOT_TBL[k]),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up       (stg[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn       (stg[k+1])
		);
	end

	assign data_out.valid      = vld[FRAC_BITS];
	assign rdy[FRAC_BITS]      = data_out.ready;
	assign data_out.log_value  = pack_log(stg[FRAC_BITS]);
	assign data_out.input_zero = stg[FRAC_BITS].zero;

	`FPL2_NEVER(a_stall_cause, !data_in.ready && !(data_out.valid && !data_out.ready), "input held off with no stalled result")

endmodule
